// ----- hdl/led_matrix_pwm_scan_driver_macros.svh -----
// Assertion helpers for the LED matrix scan driver.
// Every macro samples on the rising edge of the local clock and is
// disabled while the local reset is high.
`ifndef LED_MATRIX_PWM_SCAN_DRIVER_MACROS_SVH
`define LED_MATRIX_PWM_SCAN_DRIVER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LMPSD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LMPSD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/lmpsd_pkg.sv -----
package lmpsd_pkg;

   localparam int FUNC_W      = 2;
   localparam int BYTE_W      = 8;
   localparam int MATRIX_SIDE = 8;
   localparam int COL_W       = 3;
   localparam int RING_BYTES  = 32;
   localparam int RING_IDX_W  = 5;
   localparam int ROW_BYTES   = MATRIX_SIDE / 2;
   localparam int LANE_W      = 2;
   localparam int MEM_ROWS    = 2 * MATRIX_SIDE;
   localparam int MEM_ADDR_W  = COL_W + 1;
   localparam int ROW_W       = ROW_BYTES * BYTE_W;
   localparam int PWM_SLOTS   = 63;
   localparam int SLOT_W      = 6;
   localparam int NIB_W       = 4;

   localparam logic [FUNC_W-1:0] FUNC_BYTE    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd2;

   // 4-bit color to on-slot count, linear to 8 then geometric.
   function automatic logic [SLOT_W-1:0] level_of_color(input logic [NIB_W-1:0] nib);
      logic [SLOT_W-1:0] lvl;
      case (nib)
         4'd9:    lvl = 6'd11;
         4'd10:   lvl = 6'd15;
         4'd11:   lvl = 6'd20;
         4'd12:   lvl = 6'd26;
         4'd13:   lvl = 6'd35;
         4'd14:   lvl = 6'd47;
         4'd15:   lvl = 6'd63;
         default: lvl = {2'b00, nib};
      endcase
      return lvl;
   endfunction

endpackage

// ----- hdl/lmpsd_ifs.sv -----
interface lmpsd_req_if;
   logic                           valid;
   logic                           ready;
   logic [lmpsd_pkg::FUNC_W-1:0]   func;
   logic [lmpsd_pkg::BYTE_W-1:0]   spi_byte;

   modport source (output valid, func, spi_byte, input ready);
   modport sink   (input valid, func, spi_byte, output ready);
endinterface

interface lmpsd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [lmpsd_pkg::BYTE_W-1:0]      miso_byte;
   logic [lmpsd_pkg::MATRIX_SIDE-1:0] col_drive;
   logic [lmpsd_pkg::MATRIX_SIDE-1:0] row_drive;
   logic                              frame_swapped;

   modport source (output valid, miso_byte, col_drive, row_drive, frame_swapped,
                   input ready);
   modport sink   (input valid, miso_byte, col_drive, row_drive, frame_swapped,
                   output ready);
endinterface

// ----- hdl/led_matrix_pwm_scan_driver.sv -----
// Channel   | Dir | Words carried
// ----------+-----+------------------------------------------------------
// req_chan  | in  | func, spi_byte: serial byte, chip-select release, tick
// rsp_chan  | out | miso_byte, col_drive, row_drive, frame_swapped
//
// One word is taken per clock unless stalled; each word yields one result word.
// The frame memory has one write port and two registered read ports, which set
// the two-stage depth: read at accept time, decode into the result register.
// Reset is synchronous and active high; reset clears all control state and the
// per-byte valid bits, so the frame banks read as zero until written.
// A stalled result holds the pipeline; req_chan.ready drops only while both the
// read stage and the result register are full and the result is not taken.

`include "led_matrix_pwm_scan_driver_macros.svh"

module led_matrix_pwm_scan_driver (
   input  logic        clock,
   input  logic        reset,
   lmpsd_req_if.sink   req_chan,
   lmpsd_rsp_if.source rsp_chan
);

   // Read stage contents: everything the result decode needs, captured at the
   // edge where the word is accepted.
   typedef struct packed {
      logic [lmpsd_pkg::FUNC_W-1:0]    func;
      logic                            swapped;
      logic [lmpsd_pkg::COL_W-1:0]     col;
      logic [lmpsd_pkg::SLOT_W-1:0]    slot;
      logic [lmpsd_pkg::LANE_W-1:0]    lane;
      logic [lmpsd_pkg::ROW_BYTES-1:0] show_valid;
      logic [lmpsd_pkg::ROW_BYTES-1:0] rx_valid;
   } stage_type;

   // Architectural state.
   logic                              receive_bank_ff, receive_bank_in;
   logic [lmpsd_pkg::RING_IDX_W-1:0]  ring_index_ff, ring_index_in;
   logic                              byte_seen_ff, byte_seen_in;
   logic [lmpsd_pkg::COL_W-1:0]       scan_column_ff, scan_column_in;
   logic [lmpsd_pkg::SLOT_W-1:0]      pwm_slot_ff, pwm_slot_in;

   // The two banks share one memory. A row is one matrix column (four bytes),
   // addressed by {bank, column}. The ring index maps to row index[4:2] and
   // byte lane index[1:0], matching the pixel layout col*4 + row/2.
   logic [lmpsd_pkg::ROW_W-1:0]       frame_mem_ff [lmpsd_pkg::MEM_ROWS];
   logic [2*lmpsd_pkg::RING_BYTES-1:0] valid_ff;

   // Pipeline registers.
   logic                              sa_valid_ff, sa_valid_in;
   stage_type                         sa_ff, sa_in;
   logic [lmpsd_pkg::ROW_W-1:0]       show_row_ff;
   logic [lmpsd_pkg::ROW_W-1:0]       rx_row_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [lmpsd_pkg::BYTE_W-1:0]      miso_ff, miso_in;
   logic [lmpsd_pkg::MATRIX_SIDE-1:0] col_drive_ff, col_drive_in;
   logic [lmpsd_pkg::MATRIX_SIDE-1:0] row_drive_ff, row_drive_in;
   logic                              swapped_ff, swapped_in;

   // Handshake and addressing.
   logic                              out_load;
   logic                              sa_adv;
   logic                              accept;
   logic                              do_byte, do_swap, do_tick;
   logic [lmpsd_pkg::RING_IDX_W-1:0]  index_next;
   logic [lmpsd_pkg::MEM_ADDR_W-1:0]  wr_addr, show_addr, rx_addr;
   logic                              slot_wrap;

   // The result register loads whenever it is empty or being drained; the read
   // stage moves forward into it at the same time.
   assign out_load       = !rsp_valid_ff || rsp_chan.ready;
   assign sa_adv         = sa_valid_ff && out_load;
   assign req_chan.ready = !sa_valid_ff || out_load;
   assign accept         = req_chan.valid && req_chan.ready;

   assign do_byte = accept && (req_chan.func == lmpsd_pkg::FUNC_BYTE);
   assign do_swap = accept && (req_chan.func == lmpsd_pkg::FUNC_RELEASE) && byte_seen_ff;
   assign do_tick = accept && (req_chan.func == lmpsd_pkg::FUNC_TICK);

   assign index_next = ring_index_ff + lmpsd_pkg::RING_IDX_W'(1);
   assign wr_addr    = {receive_bank_ff,
                        ring_index_ff[lmpsd_pkg::RING_IDX_W-1:lmpsd_pkg::LANE_W]};
   assign rx_addr    = {receive_bank_ff,
                        index_next[lmpsd_pkg::RING_IDX_W-1:lmpsd_pkg::LANE_W]};
   assign show_addr  = {!receive_bank_ff, scan_column_ff};

   // A slot at or past the last one wraps to zero and steps the column.
   assign slot_wrap = ((lmpsd_pkg::SLOT_W+1)'(pwm_slot_ff) + (lmpsd_pkg::SLOT_W+1)'(1))
                      >= (lmpsd_pkg::SLOT_W+1)'(lmpsd_pkg::PWM_SLOTS);

   always_comb begin
      receive_bank_in = receive_bank_ff;
      ring_index_in   = ring_index_ff;
      byte_seen_in    = byte_seen_ff;
      scan_column_in  = scan_column_ff;
      pwm_slot_in     = pwm_slot_ff;
      if (do_byte) begin
         ring_index_in = index_next;
         byte_seen_in  = 1'b1;
      end
      if (do_swap) begin
         receive_bank_in = !receive_bank_ff;
         ring_index_in   = '0;
         byte_seen_in    = 1'b0;
      end
      if (do_tick) begin
         if (slot_wrap) begin
            pwm_slot_in    = '0;
            scan_column_in = scan_column_ff + lmpsd_pkg::COL_W'(1);
         end else begin
            pwm_slot_in = pwm_slot_ff + lmpsd_pkg::SLOT_W'(1);
         end
      end
   end

   // Capture of the per-word context. The valid bits are sampled with the
   // same old-contents view as the memory reads below.
   always_comb begin
      sa_in.func       = req_chan.func;
      sa_in.swapped    = do_swap;
      sa_in.col        = scan_column_ff;
      sa_in.slot       = pwm_slot_ff;
      sa_in.lane       = index_next[lmpsd_pkg::LANE_W-1:0];
      sa_in.show_valid = valid_ff[{show_addr, {lmpsd_pkg::LANE_W{1'b0}}} +: lmpsd_pkg::ROW_BYTES];
      sa_in.rx_valid   = valid_ff[{rx_addr, {lmpsd_pkg::LANE_W{1'b0}}} +: lmpsd_pkg::ROW_BYTES];
      if (sa_adv && !accept) begin
         sa_valid_in = 1'b0;
      end else if (accept) begin
         sa_valid_in = 1'b1;
      end else begin
         sa_valid_in = sa_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receive_bank_ff <= 1'b0;
         ring_index_ff   <= '0;
         byte_seen_ff    <= 1'b0;
         scan_column_ff  <= '0;
         pwm_slot_ff     <= '0;
         valid_ff        <= '0;
         sa_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         receive_bank_ff <= receive_bank_in;
         ring_index_ff   <= ring_index_in;
         byte_seen_ff    <= byte_seen_in;
         scan_column_ff  <= scan_column_in;
         pwm_slot_ff     <= pwm_slot_in;
         sa_valid_ff     <= sa_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (do_byte) begin
            valid_ff[{receive_bank_ff, ring_index_ff}] <= 1'b1;
         end
      end
   end

   // Frame memory: one byte-lane write, two registered reads. Reads see the
   // contents from before this edge's write; the byte being read on a receive
   // is never the byte being written.
   always_ff @(posedge clock) begin
      if (do_byte) begin
         frame_mem_ff[wr_addr][ring_index_ff[lmpsd_pkg::LANE_W-1:0]*lmpsd_pkg::BYTE_W
                               +: lmpsd_pkg::BYTE_W] <= req_chan.spi_byte;
      end
      if (accept) begin
         show_row_ff <= frame_mem_ff[show_addr];
         rx_row_ff   <= frame_mem_ff[rx_addr];
         sa_ff       <= sa_in;
      end
   end

   // Result decode. Bytes never written read as zero through the valid mask.
   always_comb begin
      logic [lmpsd_pkg::BYTE_W-1:0] pix_byte;
      logic [lmpsd_pkg::NIB_W-1:0]  nib;
      miso_in      = '0;
      col_drive_in = '0;
      row_drive_in = '0;
      swapped_in   = sa_ff.swapped;
      pix_byte     = '0;
      nib          = '0;
      if (sa_ff.func == lmpsd_pkg::FUNC_BYTE && sa_ff.rx_valid[sa_ff.lane]) begin
         miso_in = rx_row_ff[sa_ff.lane*lmpsd_pkg::BYTE_W +: lmpsd_pkg::BYTE_W];
      end
      if (sa_ff.func == lmpsd_pkg::FUNC_TICK) begin
         col_drive_in = {{(lmpsd_pkg::MATRIX_SIDE-1){1'b0}}, 1'b1} << sa_ff.col;
         for (int r = 0; r < lmpsd_pkg::MATRIX_SIDE; r++) begin
            pix_byte = sa_ff.show_valid[r/2]
                       ? show_row_ff[(r/2)*lmpsd_pkg::BYTE_W +: lmpsd_pkg::BYTE_W] : '0;
            nib = (r % 2 == 1) ? pix_byte[lmpsd_pkg::BYTE_W-1:lmpsd_pkg::NIB_W]
                               : pix_byte[lmpsd_pkg::NIB_W-1:0];
            row_drive_in[r] = sa_ff.slot < lmpsd_pkg::level_of_color(nib);
         end
      end
      rsp_valid_in = out_load ? sa_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (sa_adv) begin
         miso_ff      <= miso_in;
         col_drive_ff <= col_drive_in;
         row_drive_ff <= row_drive_in;
         swapped_ff   <= swapped_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.miso_byte     = miso_ff;
   assign rsp_chan.col_drive     = col_drive_ff;
   assign rsp_chan.row_drive     = row_drive_ff;
   assign rsp_chan.frame_swapped = swapped_ff;

   // A swap leaves the ring at its start with no pending bytes.
   `LMPSD_ASSERT_NEXT(a_swap_clears_ring, do_swap, ring_index_ff == '0 && !byte_seen_ff, "swap did not reset ring")
   // The slot counter never leaves its range.
   `LMPSD_ASSERT_SAME(a_slot_in_range, 1'b1, pwm_slot_ff < lmpsd_pkg::SLOT_W'(lmpsd_pkg::PWM_SLOTS), "pwm slot out of range")
   // A word held in the read stage is not dropped while the result is blocked.
   `LMPSD_ASSERT_NEXT(a_stage_holds, sa_valid_ff && !sa_adv, sa_valid_ff, "read stage lost a word")
   // A result that drives a column drives exactly one, with no MISO byte and no swap.
   `LMPSD_ASSERT_SAME(a_col_onehot, rsp_valid_ff && col_drive_ff != '0, $onehot(col_drive_ff) && miso_ff == '0 && !swapped_ff, "bad column drive")

endmodule

// ----- verif/led_matrix_pwm_scan_driver_tb.sv -----
module led_matrix_pwm_scan_driver_tb;

   // Func code 3 has no meaning to the block; it must answer with an all-zero word.
   localparam logic [lmpsd_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   // The block takes a word per clock unless stalled, via a read stage and a result
   // register, so a short settle after the last result is plenty before the verdict.
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int LONG_HOLD     = 400;
   localparam int PHASE_WORDS   = 300;

   // On-slot count for each 4-bit color: linear up to 8, roughly geometric above.
   localparam logic [lmpsd_pkg::SLOT_W-1:0] DUTY_OF_COLOR [16] = '{
      6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7,
      6'd8, 6'd11, 6'd15, 6'd20, 6'd26, 6'd35, 6'd47, 6'd63
   };

   typedef struct packed {
      logic [lmpsd_pkg::BYTE_W-1:0]      miso_byte;
      logic [lmpsd_pkg::MATRIX_SIDE-1:0] col_drive;
      logic [lmpsd_pkg::MATRIX_SIDE-1:0] row_drive;
      logic                              frame_swapped;
   } scan_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lmpsd_req_if req_chan ();
   lmpsd_rsp_if rsp_chan ();

   led_matrix_pwm_scan_driver dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the driver state. Both frame banks live in one array that
   // is indexed by bank number; the show bank is always the one not receiving.
   logic [lmpsd_pkg::BYTE_W-1:0]     frame_mem [2][lmpsd_pkg::RING_BYTES];
   logic                             rx_bank;
   logic [lmpsd_pkg::RING_IDX_W-1:0] ring_pos;
   logic                             got_byte;
   logic [lmpsd_pkg::COL_W-1:0]      scan_col;
   logic [lmpsd_pkg::SLOT_W-1:0]     pwm_slot;

   scan_word_type pending_scan_words [$];

   int mismatches       = 0;
   int cycle_count      = 0;
   int sender_gap_pct   = 0;
   int receiver_gap_pct = 0;
   int hold_request     = 0;
   int hold_left        = 0;

   // Every mismatch goes through here: one line printed and one count added.
   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   // Computes the word the block must answer for one accepted request word and
   // advances the shadow state exactly as the hardware does.
   function automatic scan_word_type predict_scan_word(
      input logic [lmpsd_pkg::FUNC_W-1:0] fn,
      input logic [lmpsd_pkg::BYTE_W-1:0] data);
      scan_word_type                w;
      logic [lmpsd_pkg::BYTE_W-1:0] pair;
      logic [lmpsd_pkg::NIB_W-1:0]  nib;
      w = '0;
      case (fn)
         lmpsd_pkg::FUNC_BYTE: begin
            // The byte lands at the current ring slot, and the answer is what
            // already sits at the next slot of the same bank.
            frame_mem[rx_bank][ring_pos] = data;
            ring_pos = ring_pos + 1'b1;
            w.miso_byte = frame_mem[rx_bank][ring_pos];
            got_byte = 1'b1;
         end
         lmpsd_pkg::FUNC_RELEASE: begin
            // A release only swaps the banks if a byte came in since the last swap.
            if (got_byte) begin
               rx_bank = ~rx_bank;
               ring_pos = '0;
               got_byte = 1'b0;
               w.frame_swapped = 1'b1;
            end
         end
         lmpsd_pkg::FUNC_TICK: begin
            w.col_drive = 8'b1 << scan_col;
            for (int r = 0; r < lmpsd_pkg::MATRIX_SIDE; r++) begin
               pair = frame_mem[~rx_bank][scan_col * lmpsd_pkg::ROW_BYTES + r / 2];
               nib = r[0] ? pair[7:4] : pair[3:0];
               if (pwm_slot < DUTY_OF_COLOR[nib])
                  w.row_drive[r] = 1'b1;
            end
            // The last slot wraps to zero and moves the scan to the next column.
            if (int'(pwm_slot) + 1 >= lmpsd_pkg::PWM_SLOTS) begin
               pwm_slot = '0;
               scan_col = scan_col + 1'b1;
            end else begin
               pwm_slot = pwm_slot + 1'b1;
            end
         end
         default: ;
      endcase
      return w;
   endfunction

   // Offers one request word and waits for the block to take it. The task is
   // entered at a falling edge and returns at a falling edge, so valid is
   // assigned once per time step and a back-to-back word keeps valid high.
   task automatic send_word(input logic [lmpsd_pkg::FUNC_W-1:0] fn,
                            input logic [lmpsd_pkg::BYTE_W-1:0] data);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.func     <= fn;
      req_chan.spi_byte <= data;
      do
         @(posedge clock);
      while (!req_chan.ready);
      pending_scan_words.push_back(predict_scan_word(fn, data));
      @(negedge clock);
   endtask

   // Stops offering words and waits until every outstanding result has come out.
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      while (pending_scan_words.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // The result side. Ready changes on the falling edge; a requested hold-off
   // is loaded here and counted down cycle by cycle with ready held low.
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= receiver_gap_pct);
      end
   end

   // Every taken result word is matched against the oldest prediction.
   always @(posedge clock) begin : check_results
      scan_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_scan_words.size() == 0) begin
            report_mismatch("result word arrived with nothing outstanding");
         end else begin
            want = pending_scan_words.pop_front();
            if (rsp_chan.miso_byte !== want.miso_byte)
               report_mismatch($sformatf("miso_byte got %h expected %h",
                                         rsp_chan.miso_byte, want.miso_byte));
            if (rsp_chan.col_drive !== want.col_drive)
               report_mismatch($sformatf("col_drive got %b expected %b",
                                         rsp_chan.col_drive, want.col_drive));
            if (rsp_chan.row_drive !== want.row_drive)
               report_mismatch($sformatf("row_drive got %b expected %b",
                                         rsp_chan.row_drive, want.row_drive));
            if (rsp_chan.frame_swapped !== want.frame_swapped)
               report_mismatch($sformatf("frame_swapped got %b expected %b",
                                         rsp_chan.frame_swapped, want.frame_swapped));
         end
      end
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Hand-picked words: a tick on the blank frame, a release with nothing
   // received, the unused code, bytes at both extremes and both half-lit
   // patterns, a swap followed by a second release that must not swap, and
   // ticks that show the freshly swapped frame.
   task automatic test_directed_cases();
      send_word(lmpsd_pkg::FUNC_TICK, 8'h00);
      send_word(lmpsd_pkg::FUNC_RELEASE, 8'hFF);
      send_word(FUNC_UNUSED, 8'hFF);
      send_word(lmpsd_pkg::FUNC_BYTE, 8'hFF);
      send_word(lmpsd_pkg::FUNC_BYTE, 8'h00);
      send_word(lmpsd_pkg::FUNC_BYTE, 8'h0F);
      send_word(lmpsd_pkg::FUNC_BYTE, 8'hF0);
      send_word(lmpsd_pkg::FUNC_BYTE, 8'h9C);
      send_word(lmpsd_pkg::FUNC_RELEASE, 8'h00);
      send_word(lmpsd_pkg::FUNC_RELEASE, 8'hAA);
      repeat (4) send_word(lmpsd_pkg::FUNC_TICK, 8'hFF);
      send_word(lmpsd_pkg::FUNC_BYTE, 8'h5A);
      send_word(lmpsd_pkg::FUNC_BYTE, 8'hA5);
      send_word(FUNC_UNUSED, 8'h00);
      send_word(lmpsd_pkg::FUNC_TICK, 8'h55);
      send_word(lmpsd_pkg::FUNC_RELEASE, 8'h00);
      send_word(lmpsd_pkg::FUNC_TICK, 8'h00);
      send_word(lmpsd_pkg::FUNC_BYTE, 8'h01);
      send_word(lmpsd_pkg::FUNC_BYTE, 8'h80);
      send_word(lmpsd_pkg::FUNC_RELEASE, 8'h7F);
      send_word(lmpsd_pkg::FUNC_TICK, 8'h80);
   endtask

   // Mostly well-formed traffic: whole or partial frame loads closed by a
   // release, and long runs of scan ticks so that the slot counter wraps and
   // the scan walks through every column. A small share is random noise,
   // including the unused code and releases in odd places.
   task automatic run_scan_traffic(input int word_budget);
      int sent;
      int kind;
      int len;
      sent = 0;
      while (sent < word_budget) begin
         kind = $urandom_range(9);
         if (kind < 3) begin
            // Frame loads are usually a full 32 bytes; some are short or wrap the ring.
            len = ($urandom_range(3) == 0) ? $urandom_range(1, 40) : lmpsd_pkg::RING_BYTES;
            repeat (len) send_word(lmpsd_pkg::FUNC_BYTE,
                                   lmpsd_pkg::BYTE_W'($urandom_range(255)));
            send_word(lmpsd_pkg::FUNC_RELEASE, lmpsd_pkg::BYTE_W'($urandom_range(255)));
            sent += len + 1;
         end else if (kind < 8) begin
            len = $urandom_range(20, 160);
            repeat (len) send_word(lmpsd_pkg::FUNC_TICK,
                                   lmpsd_pkg::BYTE_W'($urandom_range(255)));
            sent += len;
         end else begin
            len = $urandom_range(1, 12);
            repeat (len) send_word(lmpsd_pkg::FUNC_W'($urandom_range(3)),
                                   lmpsd_pkg::BYTE_W'($urandom_range(255)));
            sent += len;
         end
      end
   endtask

   task automatic test_random_idle_phases();
      // Sender mostly busy, receiver mostly stalling.
      sender_gap_pct = 19;
      receiver_gap_pct = 79;
      run_scan_traffic(PHASE_WORDS);
      // Sender mostly idle, receiver mostly ready.
      sender_gap_pct = 79;
      receiver_gap_pct = 19;
      run_scan_traffic(PHASE_WORDS);
      // Full rate on both sides.
      sender_gap_pct = 0;
      receiver_gap_pct = 0;
      run_scan_traffic(PHASE_WORDS);
   endtask

   // The receiver holds ready low for a long stretch while words keep coming,
   // so the pipeline fills and the block has to push back on its input.
   task automatic test_result_backpressure();
      sender_gap_pct = 0;
      receiver_gap_pct = 0;
      hold_request = LONG_HOLD;
      repeat (6) send_word(lmpsd_pkg::FUNC_BYTE, lmpsd_pkg::BYTE_W'($urandom_range(255)));
      send_word(lmpsd_pkg::FUNC_RELEASE, lmpsd_pkg::BYTE_W'($urandom_range(255)));
      repeat (30) send_word(lmpsd_pkg::FUNC_TICK, lmpsd_pkg::BYTE_W'($urandom_range(255)));
   endtask

   // The sender stops until the pipeline is completely empty between a frame
   // load, its release and the ticks that show it.
   task automatic test_pause_until_drained();
      sender_gap_pct = 19;
      receiver_gap_pct = 19;
      repeat (8) send_word(lmpsd_pkg::FUNC_BYTE, lmpsd_pkg::BYTE_W'($urandom_range(255)));
      wait_for_results();
      send_word(lmpsd_pkg::FUNC_RELEASE, 8'h00);
      wait_for_results();
      repeat (20) send_word(lmpsd_pkg::FUNC_TICK, lmpsd_pkg::BYTE_W'($urandom_range(255)));
   endtask

   initial begin
      req_chan.valid    = 1'b0;
      req_chan.func     = lmpsd_pkg::FUNC_BYTE;
      req_chan.spi_byte = '0;
      rsp_chan.ready    = 1'b0;

      // Shadow state matches the block right after reset.
      for (int b = 0; b < 2; b++)
         for (int i = 0; i < lmpsd_pkg::RING_BYTES; i++)
            frame_mem[b][i] = '0;
      rx_bank  = 1'b0;
      ring_pos = '0;
      got_byte = 1'b0;
      scan_col = '0;
      pwm_slot = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      sender_gap_pct = 19;
      receiver_gap_pct = 79;
      test_directed_cases();
      test_random_idle_phases();
      test_result_backpressure();
      test_pause_until_drained();

      wait_for_results();
      if (mismatches == 0 && pending_scan_words.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/lmpsd_pkg.sv
hdl/lmpsd_ifs.sv
hdl/led_matrix_pwm_scan_driver.sv
verif/led_matrix_pwm_scan_driver_tb.sv
